>>> rtl/heightfield_smooth_normals_core_defines.svh
// assertion macros for the heightfield normals block
// used by the checker, expects clk_i and rst_ni in scope
`ifndef HEIGHTFIELD_SMOOTH_NORMALS_CORE_DEFINES_SVH
`define HEIGHTFIELD_SMOOTH_NORMALS_CORE_DEFINES_SVH

// same-cycle implication
`define HSN_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("hsn assertion failed");

// next-cycle implication
`define HSN_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("hsn assertion failed");

`endif

>>> rtl/hsn_pkg.sv
// shared types, constants and saturation helpers for the heightfield normals block
// no dependencies
package hsn_pkg;

  localparam int GRID_MAX = 256;
  localparam int COL_W    = $clog2(GRID_MAX);
  localparam int ADDR_W   = COL_W + 2;
  localparam int DEPTH    = 4 * GRID_MAX;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GRID_POINTS = 3'd0,
    CFG_STRENGTH    = 3'd1,
    CFG_SPAN_X      = 3'd2,
    CFG_SPAN_Z      = 3'd3,
    CFG_SMOOTH      = 3'd4
  } cfg_idx_e;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_WR, ST_FRD, ST_FMUL, ST_FWR, ST_ERD, ST_EDIF, ST_EMUL, ST_EOUT
  } bk_state_e;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] span_x;
    logic [15:0] span_z;
  } cfg_t;

  typedef struct packed {
    logic               is_sample;
    logic signed [15:0] noise;
    logic [1:0]         row;
    logic [COL_W-1:0]   col;
    logic               fin;
    logic               emit;
    logic               e_int;
    logic [1:0]         e_row;
    logic [COL_W-1:0]   e_col;
    logic [15:0]        e_index;
    logic               e_last;
  } cmd_t;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) return 24'sh7FFFFF;
    if (v < -27'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/heightfield_smooth_normals_core.sv
// top level of the heightfield normals block: front end, command queue, back end
// depends on hsn_pkg, hsn_front, hsn_cmd_q, hsn_back
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | req_type, noise_sample
//  cfg     | input     | cfg_valid/cfg_ready | index, data
//  out     | output    | out_valid/out_ready | vertex_index, height, normals, last_vertex
//
// a sample is scaled and written; to smooth a height it reads four stored heights, sums,
// scales and writes back; a result reads one height at a border or five inside, then
// forms differences and products inside; all reads share the row store's one read port
// reset clears counters and config to defaults, the row store is not cleared
// the front accepts until two commands wait in the queue, then stalls;
// a config write holds off the input for its cycle
// a stalled output holds its register and stalls the back end, then the front via the queue
module heightfield_smooth_normals_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_req_type_i,
  input  logic signed [15:0]  in_noise_sample_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         out_vertex_index_o,
  output logic signed [23:0]  out_height_o,
  output logic signed [31:0]  out_normal_x_o,
  output logic signed [31:0]  out_normal_y_o,
  output logic signed [31:0]  out_normal_z_o,
  output logic                out_last_vertex_o
);

  logic          q_full, push, q_valid, pop;
  hsn_pkg::cmd_t cmd, head;
  hsn_pkg::cfg_t cfg;

  hsn_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_type_i, .in_noise_sample_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_full_i(q_full), .push_o(push), .cmd_o(cmd), .cfg_o(cfg)
  );

  hsn_cmd_q u_q (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .head_o(head)
  );

  hsn_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(head), .pop_o(pop), .cfg_i(cfg),
    .out_valid_o, .out_ready_i, .out_vertex_index_o, .out_height_o,
    .out_normal_x_o, .out_normal_y_o, .out_normal_z_o, .out_last_vertex_o
  );

endmodule

>>> rtl/hsn_front.sv
// front end: config registers, raster counters, classification into commands
// depends on hsn_pkg
module hsn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_req_type_i,
  input  logic signed [15:0]  in_noise_sample_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output hsn_pkg::cmd_t       cmd_o,
  output hsn_pkg::cfg_t       cfg_o
);

  logic [hsn_pkg::COL_W-1:0] nm1_q, nm1_d;
  logic [15:0] gain_q, gain_d, sx_q, sx_d, sz_q, sz_d;
  logic        smooth_q, smooth_d;
  logic [hsn_pkg::COL_W-1:0] srow_q, srow_d, scol_q, scol_d;
  logic [hsn_pkg::COL_W-1:0] erow_q, erow_d, ecol_q, ecol_d;
  logic        sfull_q, sfull_d;
  logic [15:0] eidx_q, eidx_d;

  logic accept, is_sample, do_emit, cfg_we;
  logic [hsn_pkg::COL_W-1:0] r, c, er, ec;
  logic [15:0] ei;
  logic e_last;
  int gp;

  // a config write holds off the input for that cycle
  assign in_ready_o  = !q_full_i && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign is_sample   = !in_req_type_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_o       = '{gain: gain_q, span_x: sx_q, span_z: sz_q};

  // effective counters: a sample after a complete frame restarts it
  always_comb begin
    r  = sfull_q ? '0 : srow_q;
    c  = sfull_q ? '0 : scol_q;
    er = (is_sample && sfull_q) ? '0 : erow_q;
    ec = (is_sample && sfull_q) ? '0 : ecol_q;
    ei = (is_sample && sfull_q) ? '0 : eidx_q;
    do_emit = is_sample ? (r >= 2) : sfull_q;
    e_last  = (er == nm1_q) && (ec == nm1_q);
  end

  // command build
  always_comb begin
    push_o            = accept && do_emit || accept && is_sample;
    cmd_o.is_sample   = is_sample;
    cmd_o.noise       = in_noise_sample_i;
    cmd_o.row         = r[1:0];
    cmd_o.col         = c;
    cmd_o.fin         = smooth_q && (r >= 2) && (c >= 1) && (c < nm1_q);
    cmd_o.emit        = do_emit;
    cmd_o.e_int       = (er >= 1) && (er < nm1_q) && (ec >= 1) && (ec < nm1_q);
    cmd_o.e_row       = er[1:0];
    cmd_o.e_col       = ec;
    cmd_o.e_index     = ei;
    cmd_o.e_last      = e_last;
  end

  // register and counter update
  always_comb begin
    nm1_d = nm1_q; gain_d = gain_q; sx_d = sx_q; sz_d = sz_q; smooth_d = smooth_q;
    srow_d = srow_q; scol_d = scol_q; sfull_d = sfull_q;
    erow_d = erow_q; ecol_d = ecol_q; eidx_d = eidx_q;
    gp = int'(cfg_data_i[8:0]);
    if (gp < 3) gp = 3;
    if (gp > hsn_pkg::GRID_MAX) gp = hsn_pkg::GRID_MAX;
    if (cfg_we) begin
      unique case (cfg_index_i)
        hsn_pkg::CFG_GRID_POINTS: begin
          nm1_d  = hsn_pkg::COL_W'(gp - 1);
          srow_d = '0; scol_d = '0; sfull_d = 1'b0;
          erow_d = '0; ecol_d = '0; eidx_d = '0;
        end
        hsn_pkg::CFG_STRENGTH: gain_d   = cfg_data_i;
        hsn_pkg::CFG_SPAN_X:   sx_d     = cfg_data_i;
        hsn_pkg::CFG_SPAN_Z:   sz_d     = cfg_data_i;
        hsn_pkg::CFG_SMOOTH:   smooth_d = cfg_data_i[0];
        default: ;
      endcase
    end else if (accept) begin
      if (is_sample) begin
        scol_d  = (c == nm1_q) ? '0 : c + 1'b1;
        srow_d  = (c == nm1_q) ? r + 1'b1 : r;
        sfull_d = (r == nm1_q) && (c == nm1_q);
        erow_d  = er; ecol_d = ec; eidx_d = ei;
      end
      if (do_emit) begin
        ecol_d = (ec == nm1_q) ? '0 : ec + 1'b1;
        erow_d = (ec == nm1_q) ? er + 1'b1 : er;
        eidx_d = ei + 16'd1;
        if (!is_sample && e_last) begin
          srow_d = '0; scol_d = '0; sfull_d = 1'b0;
          erow_d = '0; ecol_d = '0; eidx_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q <= hsn_pkg::COL_W'(63); gain_q <= 16'd256; sx_q <= 16'd256; sz_q <= 16'd256;
      smooth_q <= 1'b1;
      srow_q <= '0; scol_q <= '0; sfull_q <= 1'b0;
      erow_q <= '0; ecol_q <= '0; eidx_q <= '0;
    end else begin
      nm1_q <= nm1_d; gain_q <= gain_d; sx_q <= sx_d; sz_q <= sz_d; smooth_q <= smooth_d;
      srow_q <= srow_d; scol_q <= scol_d; sfull_q <= sfull_d;
      erow_q <= erow_d; ecol_q <= ecol_d; eidx_q <= eidx_d;
    end
  end

endmodule

>>> rtl/hsn_cmd_q.sv
// two-entry command queue between front and back end
// depends on hsn_pkg
module hsn_cmd_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsn_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hsn_pkg::cmd_t head_o
);

  hsn_pkg::cmd_t ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = ent_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) ent_q[wp_q] <= cmd_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= !wp_q;
      if (pop_i && valid_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && valid_o);
    end
  end

endmodule

>>> rtl/hsn_back.sv
// back end: row store, smoothing and normal sequencer, output register
// depends on hsn_pkg
module hsn_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  hsn_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  input  hsn_pkg::cfg_t       cfg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         out_vertex_index_o,
  output logic signed [23:0]  out_height_o,
  output logic signed [31:0]  out_normal_x_o,
  output logic signed [31:0]  out_normal_y_o,
  output logic signed [31:0]  out_normal_z_o,
  output logic                out_last_vertex_o
);

  hsn_pkg::bk_state_e st_q, st_d;
  hsn_pkg::cmd_t      cmd_q, cmd_d;
  logic [2:0]         k_q, k_d;

  logic signed [23:0] mem [hsn_pkg::DEPTH];
  logic signed [23:0] rd_q;
  logic                       we;
  logic [hsn_pkg::ADDR_W-1:0] wa, ra;
  logic signed [23:0]         wd;

  logic signed [32:0] hprod_q, hprod_d;
  logic signed [26:0] sum_q, sum_d;
  logic signed [42:0] sprod_q, sprod_d, rnd;
  logic signed [23:0] ht_q, ht_d, up_q, up_d, dn_q, dn_d, rt_q, rt_d, lf_q, lf_d;
  logic signed [24:0] dv_q, dv_d, dh_q, dh_d;
  logic signed [40:0] px_q, px_d, pz_q, pz_d;
  logic [31:0]        py_q, py_d;
  logic signed [33:0] nyw;
  logic signed [23:0] raw;
  logic [2:0]         kmax;
  logic               load;

  logic               ov_q, ov_d;
  logic [15:0]        oi_q, oi_d;
  logic signed [23:0] oh_q, oh_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic               ol_q, ol_d;

  assign raw  = hsn_pkg::sat24({{2{hprod_q[32]}}, hprod_q[32:8]});
  assign rnd  = sprod_q + 43'sd32768;
  assign nyw  = -$signed({2'b00, py_q});
  assign kmax = cmd_q.e_int ? 3'd5 : 3'd1;
  assign load = !ov_q || out_ready_i;

  // row store
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hsn_pkg::ST_IDLE: if (cmd_valid_i) begin
        st_d = cmd_i.is_sample ? hsn_pkg::ST_MUL : hsn_pkg::ST_ERD;
      end
      hsn_pkg::ST_MUL:  st_d = hsn_pkg::ST_WR;
      hsn_pkg::ST_WR:   st_d = cmd_q.fin ? hsn_pkg::ST_FRD :
                               cmd_q.emit ? hsn_pkg::ST_ERD : hsn_pkg::ST_IDLE;
      hsn_pkg::ST_FRD:  if (k_q == 3'd4) st_d = hsn_pkg::ST_FMUL;
      hsn_pkg::ST_FMUL: st_d = hsn_pkg::ST_FWR;
      hsn_pkg::ST_FWR:  st_d = cmd_q.emit ? hsn_pkg::ST_ERD : hsn_pkg::ST_IDLE;
      hsn_pkg::ST_ERD:  if (k_q == kmax) begin
        st_d = cmd_q.e_int ? hsn_pkg::ST_EDIF : hsn_pkg::ST_EOUT;
      end
      hsn_pkg::ST_EDIF: st_d = hsn_pkg::ST_EMUL;
      hsn_pkg::ST_EMUL: st_d = hsn_pkg::ST_EOUT;
      hsn_pkg::ST_EOUT: if (load) st_d = hsn_pkg::ST_IDLE;
      default: st_d = hsn_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d = cmd_q; k_d = '0; pop_o = 1'b0;
    we = 1'b0; wa = {cmd_q.row, cmd_q.col}; wd = raw; ra = '0;
    hprod_d = hprod_q; sum_d = sum_q; sprod_d = sprod_q;
    ht_d = ht_q; up_d = up_q; dn_d = dn_q; rt_d = rt_q; lf_d = lf_q;
    dv_d = dv_q; dh_d = dh_q; px_d = px_q; pz_d = pz_q; py_d = py_q;
    ov_d = ov_q && !out_ready_i;
    oi_d = oi_q; oh_d = oh_q; ox_d = ox_q; oy_d = oy_q; oz_d = oz_q; ol_d = ol_q;
    unique case (st_q)
      hsn_pkg::ST_IDLE: begin
        pop_o = cmd_valid_i;
        if (cmd_valid_i) cmd_d = cmd_i;
      end
      hsn_pkg::ST_MUL: hprod_d = 33'(cmd_q.noise) * $signed({17'b0, cfg_i.gain});
      hsn_pkg::ST_WR: begin
        we    = 1'b1;
        sum_d = 27'(raw);
      end
      hsn_pkg::ST_FRD: begin
        k_d = k_q + 3'd1;
        unique case (k_q)
          3'd0:    ra = {cmd_q.row - 2'd1, cmd_q.col};
          3'd1:    ra = {cmd_q.row - 2'd1, cmd_q.col + 1'b1};
          3'd2:    ra = {cmd_q.row - 2'd1, cmd_q.col - 1'b1};
          default: ra = {cmd_q.row - 2'd2, cmd_q.col};
        endcase
        if (k_q != 3'd0) sum_d = sum_q + 27'(rd_q);
      end
      hsn_pkg::ST_FMUL: sprod_d = 43'(sum_q) * 43'sd13107;
      hsn_pkg::ST_FWR: begin
        we = 1'b1;
        wa = {cmd_q.row - 2'd1, cmd_q.col};
        wd = hsn_pkg::sat24(rnd[42:16]);
      end
      hsn_pkg::ST_ERD: begin
        k_d = k_q + 3'd1;
        unique case (k_q)
          3'd0:    ra = {cmd_q.e_row, cmd_q.e_col};
          3'd1:    ra = {cmd_q.e_row + 2'd1, cmd_q.e_col};
          3'd2:    ra = {cmd_q.e_row - 2'd1, cmd_q.e_col};
          3'd3:    ra = {cmd_q.e_row, cmd_q.e_col + 1'b1};
          default: ra = {cmd_q.e_row, cmd_q.e_col - 1'b1};
        endcase
        unique case (k_q)
          3'd1:    ht_d = rd_q;
          3'd2:    up_d = rd_q;
          3'd3:    dn_d = rd_q;
          3'd4:    rt_d = rd_q;
          3'd5:    lf_d = rd_q;
          default: ;
        endcase
      end
      hsn_pkg::ST_EDIF: begin
        dv_d = 25'(up_q) - 25'(dn_q);
        dh_d = 25'(rt_q) - 25'(lf_q);
      end
      hsn_pkg::ST_EMUL: begin
        px_d = 41'(dv_q) * $signed({25'b0, cfg_i.span_z});
        pz_d = 41'(dh_q) * $signed({25'b0, cfg_i.span_x});
        py_d = cfg_i.span_x * cfg_i.span_z;
      end
      hsn_pkg::ST_EOUT: begin
        if (load) begin
          ov_d = 1'b1;
          oi_d = cmd_q.e_index;
          oh_d = ht_q;
          ol_d = cmd_q.e_last;
          ox_d = cmd_q.e_int ? hsn_pkg::sat32(px_q[40:7]) : '0;
          oz_d = cmd_q.e_int ? hsn_pkg::sat32(pz_q[40:7]) : '0;
          oy_d = cmd_q.e_int ? hsn_pkg::sat32({nyw[33], nyw[33:1]}) : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hsn_pkg::ST_IDLE; k_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; hprod_q <= hprod_d; sum_q <= sum_d; sprod_q <= sprod_d;
    ht_q <= ht_d; up_q <= up_d; dn_q <= dn_d; rt_q <= rt_d; lf_q <= lf_d;
    dv_q <= dv_d; dh_q <= dh_d; px_q <= px_d; pz_q <= pz_d; py_q <= py_d;
    oi_q <= oi_d; oh_q <= oh_d; ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d; ol_q <= ol_d;
  end

  assign out_valid_o        = ov_q;
  assign out_vertex_index_o = oi_q;
  assign out_height_o       = oh_q;
  assign out_normal_x_o     = ox_q;
  assign out_normal_y_o     = oy_q;
  assign out_normal_z_o     = oz_q;
  assign out_last_vertex_o  = ol_q;

endmodule

>>> rtl/hsn_checker.sv
// port-level checks on the heightfield normals block, bound to the top level
// depends on heightfield_smooth_normals_core_defines.svh
`include "heightfield_smooth_normals_core_defines.svh"
module hsn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [15:0]         out_vertex_index_o,
  input logic signed [23:0]  out_height_o,
  input logic signed [31:0]  out_normal_x_o,
  input logic signed [31:0]  out_normal_y_o,
  input logic signed [31:0]  out_normal_z_o,
  input logic                out_last_vertex_o
);

  // stalled result holds
  `HSN_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_height_o) && $stable(out_vertex_index_o))
  // spans are unsigned so the y normal never goes positive
  `HSN_ASSERT_IMP(a_ny_sign, out_valid_o, out_normal_y_o[31] || out_normal_y_o == 32'sd0)
  // the last vertex is a corner, so its normal is zero
  `HSN_ASSERT_IMP(a_last_border, out_valid_o && out_last_vertex_o,
    out_normal_x_o == 32'sd0 && out_normal_y_o == 32'sd0 && out_normal_z_o == 32'sd0)

endmodule

bind heightfield_smooth_normals_core hsn_checker u_hsn_checker (.*);

>>> bench/heightfield_smooth_normals_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for heightfield_smooth_normals_core: random grids, gains and spans
// depends on hsn_pkg and the rtl of heightfield_smooth_normals_core
module heightfield_smooth_normals_core_tb;

  typedef struct packed {
    logic [15:0]        index;
    logic signed [23:0] height;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               last;
  } vertex_t;

  // tracks grid state and holds the vertices still owed by the block
  class heightfield_board;
    int unsigned grid_reg, gain, span_x, span_z;
    bit          smooth_on;
    int          heights[4*hsn_pkg::GRID_MAX];
    int unsigned taken, emitted;
    vertex_t     owed[$];
    int          mismatches, vertices_checked;

    function new();
      grid_reg = 64; gain = 256; span_x = 256; span_z = 256; smooth_on = 1;
      taken = 0; emitted = 0; mismatches = 0; vertices_checked = 0;
    endfunction

    function int unsigned side();
      if (grid_reg < 3) return 3;
      if (grid_reg > hsn_pkg::GRID_MAX) return hsn_pkg::GRID_MAX;
      return grid_reg;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function int unsigned slot(int unsigned r, int unsigned c);
      return (r % 4) * hsn_pkg::GRID_MAX + c;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        hsn_pkg::CFG_GRID_POINTS: begin
          grid_reg = d[8:0]; taken = 0; emitted = 0;
        end
        hsn_pkg::CFG_STRENGTH: gain = d;
        hsn_pkg::CFG_SPAN_X:   span_x = d;
        hsn_pkg::CFG_SPAN_Z:   span_z = d;
        hsn_pkg::CFG_SMOOTH:   smooth_on = d[0];
        default: ;
      endcase
    endfunction

    // five point average, left and upper neighbors already smoothed
    function void smooth_at(int unsigned r, int unsigned c, int unsigned n);
      longint sum;
      if (!smooth_on || r < 1 || r > n - 2 || c < 1 || c > n - 2) return;
      sum = longint'(heights[slot(r, c)]) + heights[slot(r, c + 1)]
          + heights[slot(r, c - 1)] + heights[slot(r + 1, c)] + heights[slot(r - 1, c)];
      heights[slot(r, c)] = int'(clip((sum * 13107 + 32768) >>> 16, 24));
    endfunction

    function void owe_vertex(int unsigned e, int unsigned n);
      int unsigned r, c;
      longint dv, dh;
      vertex_t v;
      r = e / n;
      c = e % n;
      v = '0;
      if (r >= 1 && r <= n - 2 && c >= 1 && c <= n - 2) begin
        dv = longint'(heights[slot(r + 1, c)]) - heights[slot(r - 1, c)];
        dh = longint'(heights[slot(r, c + 1)]) - heights[slot(r, c - 1)];
        v.nx = 32'(clip((2 * longint'(span_z) * dv) >>> 8, 32));
        v.ny = 32'(clip((-4 * longint'(span_x) * longint'(span_z)) >>> 3, 32));
        v.nz = 32'(clip((2 * longint'(span_x) * dh) >>> 8, 32));
      end
      v.index  = e[15:0];
      v.height = 24'(heights[slot(r, c)]);
      v.last   = (e == n * n - 1);
      owed.push_back(v);
      emitted = e + 1;
      if (emitted >= n * n) begin
        emitted = 0; taken = 0;
      end
    endfunction

    function void take_request(bit drain, logic signed [15:0] x);
      int unsigned n, s, r, c;
      n = side();
      if (!drain) begin
        if (taken >= n * n) begin
          taken = 0; emitted = 0;
        end
        s = taken;
        r = s / n;
        c = s % n;
        heights[slot(r, c)] = int'(clip((longint'(x) * longint'(gain)) >>> 8, 24));
        taken = s + 1;
        if (r >= 1) smooth_at(r - 1, c, n);
        if (s >= 2 * n) owe_vertex(s - 2 * n, n);
      end else if (taken >= n * n && emitted < n * n) begin
        owe_vertex(emitted, n);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      vertices_checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex %0d height %0d", got.index, got.height);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("vertex mismatch: want idx %0d h %0d n %0d %0d %0d last %0d",
                   want.index, want.height, want.nx, want.ny, want.nz, want.last);
          $display("                 got  idx %0d h %0d n %0d %0d %0d last %0d",
                   got.index, got.height, got.nx, got.ny, got.nz, got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i, in_ready_o, in_req_type_i;
  logic signed [15:0] in_noise_sample_i;
  logic               cfg_valid_i, cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               out_valid_o, out_ready_i;
  logic [15:0]        out_vertex_index_o;
  logic signed [23:0] out_height_o;
  logic signed [31:0] out_normal_x_o, out_normal_y_o, out_normal_z_o;
  logic               out_last_vertex_o;

  heightfield_smooth_normals_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_req_type_i      (in_req_type_i),
    .in_noise_sample_i  (in_noise_sample_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_vertex_index_o (out_vertex_index_o),
    .out_height_o       (out_height_o),
    .out_normal_x_o     (out_normal_x_o),
    .out_normal_y_o     (out_normal_y_o),
    .out_normal_z_o     (out_normal_z_o),
    .out_last_vertex_o  (out_last_vertex_o)
  );

  heightfield_board board = new();
  int unsigned      items_sent = 0, samples_sent = 0, phases_run = 0;
  int unsigned      send_idle_pct = 37, recv_idle_pct = 79;

  always #5 clk_i = ~clk_i;

  // idle pattern: sender light and receiver heavy, then swapped, then none
  always @(negedge clk_i) begin
    send_idle_pct <= (items_sent < 230) ? 37 : (items_sent < 460) ? 79 : 0;
    recv_idle_pct <= (items_sent < 230) ? 79 : (items_sent < 460) ? 37 : 0;
    out_ready_i   <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_vertex(vertex_t'({out_vertex_index_o, out_height_o, out_normal_x_o,
                                    out_normal_y_o, out_normal_z_o, out_last_vertex_o}));
  end

  initial begin
    #30ms;
    $display("timeout with %0d vertices owed", board.owed.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [15:0] pick_noise();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // returns right after the accepting edge; valid stays up for a following item
  task automatic send_req(bit drain, logic signed [15:0] x);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    in_req_type_i     = drain;
    in_noise_sample_i = x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_request(drain, x);
    items_sent++;
    if (!drain) samples_sent++;
  endtask

  // hold off input until every owed vertex is out, then let the back end settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_span();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(128, 1024));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic run_frames(int unsigned budget, bit hold_midway);
    int unsigned n, k, stop, start_cnt;
    start_cnt = samples_sent;
    while (samples_sent - start_cnt < budget) begin
      n = board.side();
      case ($urandom_range(9))
        // random mix of samples and drains
        0: begin
          repeat ($urandom_range(1, 12)) send_req(1'($urandom_range(1)), pick_noise());
        end
        // full frame whose drains are cut short by the next one
        1: begin
          for (k = 0; k < n * n; k++) send_req(1'b0, pick_noise());
          repeat ($urandom_range(0, 2 * n - 1)) send_req(1'b1, '0);
        end
        default: begin
          for (k = 0; k < n * n; k++) begin
            if ($urandom_range(19) == 0) send_req(1'b1, '0);
            send_req(1'b0, pick_noise());
            if (hold_midway && k == n * n / 2) begin
              wait_drained();
              hold_midway = 0;
            end
          end
          stop = 2 * n + $urandom_range(2);
          repeat (stop) send_req(1'b1, '0);
        end
      endcase
    end
  endtask

  initial begin
    int unsigned g;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_req_type_i = 1'b0; in_noise_sample_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest grid, saturating gain and spans, drain corner cases
    write_reg(hsn_pkg::CFG_GRID_POINTS, 16'd3);
    write_reg(hsn_pkg::CFG_STRENGTH, 16'hFFFF);
    write_reg(hsn_pkg::CFG_SPAN_X, 16'hFFFF);
    write_reg(hsn_pkg::CFG_SPAN_Z, 16'hFFFF);
    write_reg(hsn_pkg::CFG_SMOOTH, 16'd1);
    write_reg(3'd7, 16'hFFFF);
    send_req(1'b1, '0);
    send_req(1'b0, 16'sh8000); send_req(1'b0, 16'sh7FFF); send_req(1'b0, 16'sh0000);
    send_req(1'b0, -16'sd1);   send_req(1'b0, 16'sh7FFF); send_req(1'b0, 16'sh8000);
    send_req(1'b0, 16'sd1);    send_req(1'b0, 16'sh7FFF); send_req(1'b0, 16'sh8000);
    send_req(1'b1, '0);
    send_req(1'b1, '0);
    // sample on a finished but undrained frame starts a new one
    send_req(1'b0, 16'sd12345);
    wait_drained();
    write_reg(hsn_pkg::CFG_GRID_POINTS, 16'd0);
    write_reg(hsn_pkg::CFG_STRENGTH, 16'd256);
    write_reg(hsn_pkg::CFG_SMOOTH, 16'd0);
    repeat (9) send_req(1'b0, pick_noise());
    repeat (4) send_req(1'b1, '0);
    wait_drained();

    // random phases over grid sizes and register settings
    while (samples_sent < 140) begin
      phases_run++;
      case ($urandom_range(9))
        0: g = $urandom_range(0, 2);
        1: g = $urandom_range(11, 16);
        default: g = $urandom_range(3, 10);
      endcase
      write_reg(hsn_pkg::CFG_GRID_POINTS, 16'(g));
      case ($urandom_range(4))
        0: write_reg(hsn_pkg::CFG_STRENGTH, 16'd0);
        1: write_reg(hsn_pkg::CFG_STRENGTH, 16'hFFFF);
        2: write_reg(hsn_pkg::CFG_STRENGTH, 16'($urandom_range(64, 1024)));
        default: write_reg(hsn_pkg::CFG_STRENGTH, 16'($urandom));
      endcase
      write_reg(hsn_pkg::CFG_SPAN_X, pick_span());
      write_reg(hsn_pkg::CFG_SPAN_Z, pick_span());
      write_reg(hsn_pkg::CFG_SMOOTH, 16'($urandom));
      if ($urandom_range(3) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      run_frames(40, phases_run == 2);
      wait_drained();
    end

    // largest grid through the clamp, far enough for the first results
    write_reg(hsn_pkg::CFG_GRID_POINTS, 16'h01FF);
    write_reg(hsn_pkg::CFG_SMOOTH, 16'd1);
    repeat (2 * hsn_pkg::GRID_MAX + 4) send_req(1'b0, pick_noise());
    wait_drained();
    write_reg(hsn_pkg::CFG_GRID_POINTS, 16'd5);
    run_frames(20, 1'b0);
    wait_drained();

    $display("covered %0d transfers in, %0d vertices checked over %0d random phases",
             items_sent, board.vertices_checked, phases_run);
    $display("grids from 3 to 256 points, gain and spans at both ends, smoothing on and off");
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d vertices owed", board.mismatches, board.owed.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hsn_pkg.sv
rtl/hsn_front.sv
rtl/hsn_cmd_q.sv
rtl/hsn_back.sv
rtl/heightfield_smooth_normals_core.sv
rtl/hsn_checker.sv
bench/heightfield_smooth_normals_core_tb.sv
